// ===== rtl/core/epoch_civil_date_converter_macros.svh =====
// Assertion macros for the civil date and epoch converter.
// Used by the checker module; needs a clock named clk and a reset named rst_n in scope.
`ifndef EPOCH_CIVIL_DATE_CONVERTER_MACROS_SVH
`define EPOCH_CIVIL_DATE_CONVERTER_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ECDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked at every clock edge, reset included.
`define ECDC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/ecdc_pkg.sv =====
// Package for the civil date and epoch converter: constants, field layout and tables.
// Used by the converter top level and by its checker; depends on nothing.
package ecdc_pkg;

  // Command codes carried on tuser.
  localparam logic CMD_TO_EPOCH = 1'b0;
  localparam logic CMD_TO_CIVIL = 1'b1;

  // Calendar constants.
  localparam int unsigned BASE_YEAR      = 1948;
  localparam int unsigned UNIX_BASE_DAYS = 7977;
  localparam int unsigned SECS_PER_DAY   = 86400;
  localparam int unsigned DAYS_PER_YEAR  = 365;
  localparam int unsigned GRID_OFFSET    = 19;
  localparam int unsigned MAX_HOUR       = 24;
  localparam int unsigned YEAR_MIN       = 1970;
  localparam int unsigned YEAR_MAX       = 2099;
  localparam logic [31:0] EPOCH_LIMIT    = 32'd4102444800;

  // Rounded-up reciprocals for the constant divisions.
  // Seconds per day: (t >> 7) / 675, product shifted by DAY_SHIFT.
  localparam logic [25:0] DAY_RECIP   = 26'd50903317;
  localparam int unsigned DAY_SHIFT   = 35;
  // Days per year, product shifted by YEAR_SHIFT.
  localparam logic [15:0] YEAR_RECIP  = 16'd45965;
  localparam int unsigned YEAR_SHIFT  = 24;
  // Divide by sixty for seconds of the day.
  localparam logic [17:0] MIN_RECIP   = 18'd139811;
  localparam int unsigned MIN_SHIFT   = 23;
  // Divide by sixty for minutes of the day.
  localparam logic [11:0] HOUR_RECIP  = 12'd2185;
  localparam int unsigned HOUR_SHIFT  = 17;

  // Field layout of the data words.
  localparam int unsigned IN_DATA_W     = 72;
  localparam int unsigned OUT_DATA_W    = 72;
  localparam int unsigned OUT_EPOCH_LSB = 0;
  localparam int unsigned OUT_YEAR_LSB  = 32;
  localparam int unsigned OUT_MONTH_LSB = 44;
  localparam int unsigned OUT_DAY_LSB   = 48;
  localparam int unsigned OUT_HOUR_LSB  = 53;
  localparam int unsigned OUT_MIN_LSB   = 58;
  localparam int unsigned OUT_SEC_LSB   = 64;
  localparam int unsigned OUT_USED_MSB  = 69;

  // Days before the first of each month, in a year running from March.
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] v;
    case (m)
      4'd1:    v = 9'd306;
      4'd2:    v = 9'd337;
      4'd4:    v = 9'd31;
      4'd5:    v = 9'd61;
      4'd6:    v = 9'd92;
      4'd7:    v = 9'd122;
      4'd8:    v = 9'd153;
      4'd9:    v = 9'd184;
      4'd10:   v = 9'd214;
      4'd11:   v = 9'd245;
      4'd12:   v = 9'd275;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // Correction terms for the 32-day month grid.
  function automatic logic [4:0] grid_rem(input logic [3:0] g);
    logic [4:0] v;
    case (g)
      4'd0:    v = 5'd19;
      4'd1:    v = 5'd19;
      4'd2:    v = 5'd18;
      4'd3:    v = 5'd16;
      4'd4:    v = 5'd15;
      4'd5:    v = 5'd13;
      4'd6:    v = 5'd12;
      4'd7:    v = 5'd11;
      4'd8:    v = 5'd9;
      4'd9:    v = 5'd8;
      4'd10:   v = 5'd6;
      4'd11:   v = 5'd5;
      4'd12:   v = 5'd4;
      default: v = 5'd1;
    endcase
    return v;
  endfunction

  // Grid month to civil month.
  function automatic logic [3:0] grid_month(input logic [3:0] g);
    logic [3:0] v;
    case (g)
      4'd1:    v = 4'd3;
      4'd2:    v = 4'd4;
      4'd3:    v = 4'd5;
      4'd4:    v = 4'd6;
      4'd5:    v = 4'd7;
      4'd6:    v = 4'd8;
      4'd7:    v = 4'd9;
      4'd8:    v = 4'd10;
      4'd9:    v = 4'd11;
      4'd10:   v = 4'd12;
      4'd11:   v = 4'd1;
      4'd12:   v = 4'd2;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/epoch_civil_date_converter.sv =====
// Civil date and time to epoch seconds converter, and back, as a five-stage pipeline.
// Depends on ecdc_pkg for constants and the month tables.
// Throughput: one request per cycle unless the output stalls.
// Every division by a constant other than a power of two is a reciprocal multiply.
// Each stage holds its data while the next is full, so bubbles close up under a stall.
// Reset (synchronous, active low) empties all stages; no clearing pass is needed.
module epoch_civil_date_converter
  import ecdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata from bit 0: year[11:0], month[3:0], day[4:0], hour[4:0], minute[5:0],
  // second[5:0], epoch_in[31:0], two zero bits
  input  logic [71:0] in_tdata,
  // in_tuser: command
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata from bit 0: epoch_out[31:0], year_out[11:0], month_out[3:0], day_out[4:0],
  // hour_out[4:0], minute_out[5:0], second_out[5:0], two zero bits
  output logic [71:0] out_tdata,
  // out_tuser: out_of_range
  output logic        out_tuser
);

  // Unpacked request fields.
  logic        in_cmd;
  logic [11:0] in_year;
  logic [3:0]  in_month;
  logic [4:0]  in_day;
  logic [4:0]  in_hour;
  logic [5:0]  in_minute;
  logic [5:0]  in_second;
  logic [31:0] in_epoch;

  assign in_cmd    = in_tuser;
  assign in_year   = in_tdata[11:0];
  assign in_month  = in_tdata[15:12];
  assign in_day    = in_tdata[20:16];
  assign in_hour   = in_tdata[25:21];
  assign in_minute = in_tdata[31:26];
  assign in_second = in_tdata[37:32];
  assign in_epoch  = in_tdata[69:38];

  // Stage valid bits and the ready chain from the output backwards.
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, out_rdy;

  assign out_rdy   = !out_v_r || out_tready;
  assign s4_rdy    = !s4_v_r || out_rdy;
  assign s3_rdy    = !s3_v_r || s4_rdy;
  assign s2_rdy    = !s2_v_r || s3_rdy;
  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign in_tready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_rdy)  s1_v_r  <= in_tvalid;
      if (s2_rdy)  s2_v_r  <= s1_v_r;
      if (s3_rdy)  s3_v_r  <= s2_v_r;
      if (s4_rdy)  s4_v_r  <= s3_v_r;
      if (out_rdy) out_v_r <= s4_v_r;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Civil side: March-based year offset, day of year, seconds of the day.
  // Epoch side: day count by reciprocal multiply. The range flag is settled here.
  logic [12:0] s1_yoff_nxt, s1_yoff_r;
  logic [8:0]  s1_yday_nxt, s1_yday_r;
  logic [16:0] s1_secs_nxt, s1_secs_r;
  logic [15:0] s1_q_nxt,    s1_q_r;
  logic [31:0] s1_t_r;
  logic        s1_cmd_r;
  logic        s1_flag_nxt, s1_flag_r;
  logic        jan_feb;
  logic [4:0]  hour_clamped;
  logic [50:0] day_prod;

  always_comb begin
    // January and February belong to the March-based year before.
    jan_feb      = (in_month == 4'd1) || (in_month == 4'd2);
    s1_yoff_nxt  = {1'b0, in_year} - 13'(BASE_YEAR) - {12'd0, jan_feb};
    // A month above twelve contributes no days at all.
    s1_yday_nxt  = (in_month <= 4'd12) ? (month_start(in_month) + {4'd0, in_day}) : 9'd0;
    hour_clamped = (in_hour > 5'(MAX_HOUR)) ? 5'(MAX_HOUR) : in_hour;
    s1_secs_nxt  = {12'd0, hour_clamped} * 17'd3600 + {11'd0, in_minute} * 17'd60
                 + {11'd0, in_second};
    // Whole days: (t >> 7) / 675 with a rounded-up reciprocal is exact here.
    day_prod     = {26'd0, in_epoch[31:7]} * {25'd0, DAY_RECIP};
    s1_q_nxt     = day_prod[50:35];
    if (in_cmd == CMD_TO_EPOCH) begin
      s1_flag_nxt = (in_year < 12'(YEAR_MIN)) || (in_year > 12'(YEAR_MAX)) ||
                    (in_month < 4'd1) || (in_month > 4'd12);
    end else begin
      s1_flag_nxt = (in_epoch >= EPOCH_LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_cmd_r  <= in_cmd;
      s1_flag_r <= s1_flag_nxt;
      s1_yoff_r <= s1_yoff_nxt;
      s1_yday_r <= s1_yday_nxt;
      s1_secs_r <= s1_secs_nxt;
      s1_q_r    <= s1_q_nxt;
      s1_t_r    <= in_epoch;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Civil side: day number relative to the epoch, wrapping at 32 bits.
  // Epoch side: seconds of the day, day number from 1948, first year estimate.
  logic [31:0] yoff_ext;
  logic [31:0] s2_days_nxt, s2_days_r;
  logic [16:0] s2_secs_r;
  logic [16:0] s2_sod_nxt, s2_sod_r;
  logic [15:0] s2_d_nxt, s2_d_r;
  logic [31:0] year_prod;
  logic [7:0]  s2_by_nxt, s2_by_r;
  logic        s2_cmd_r, s2_flag_r;

  always_comb begin
    // A year before the base wraps, so the offset is sign-extended to 32 bits.
    yoff_ext    = {{19{s1_yoff_r[12]}}, s1_yoff_r};
    s2_days_nxt = yoff_ext * 32'd365 + (yoff_ext >> 2) + {23'd0, s1_yday_r}
                - 32'(UNIX_BASE_DAYS);
    s2_sod_nxt  = s1_t_r[16:0] - ({1'b0, s1_q_r} * 17'(SECS_PER_DAY));
    s2_d_nxt    = s1_q_r + 16'(UNIX_BASE_DAYS);
    year_prod   = {16'd0, s2_d_nxt} * {16'd0, YEAR_RECIP};
    s2_by_nxt   = year_prod[31:24];
  end

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      s2_cmd_r  <= s1_cmd_r;
      s2_flag_r <= s1_flag_r;
      s2_days_r <= s2_days_nxt;
      s2_secs_r <= s1_secs_r;
      s2_sod_r  <= s2_sod_nxt;
      s2_d_r    <= s2_d_nxt;
      s2_by_r   <= s2_by_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Civil side: final second count. Epoch side: year fix-up and day of year,
  // minutes of the day by reciprocal multiply.
  logic [31:0] s3_epoch_nxt, s3_epoch_r;
  logic [15:0] f0_a, f0_b;
  logic [7:0]  by_dec;
  logic [7:0]  s3_by_nxt, s3_by_r;
  logic [15:0] doy_full;
  logic [8:0]  s3_doy_r;
  logic [34:0] min_prod;
  logic [10:0] s3_m1_nxt, s3_m1_r;
  logic [16:0] s3_sod_r;
  logic        s3_cmd_r, s3_flag_r;

  always_comb begin
    s3_epoch_nxt = s2_days_r * 32'(SECS_PER_DAY) + {15'd0, s2_secs_r};
    // Start of the estimated year and of the one before; the estimate is at
    // most one year high.
    by_dec   = s2_by_r - 8'd1;
    f0_a     = {8'd0, s2_by_r} * 16'(DAYS_PER_YEAR) + {10'd0, s2_by_r[7:2]};
    f0_b     = {8'd0, by_dec} * 16'(DAYS_PER_YEAR) + {10'd0, by_dec[7:2]};
    if (f0_a >= s2_d_r) begin
      s3_by_nxt = by_dec;
      doy_full  = s2_d_r - f0_b;
    end else begin
      s3_by_nxt = s2_by_r;
      doy_full  = s2_d_r - f0_a;
    end
    min_prod  = {18'd0, s2_sod_r} * {17'd0, MIN_RECIP};
    s3_m1_nxt = min_prod[33:23];
  end

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      s3_cmd_r   <= s2_cmd_r;
      s3_flag_r  <= s2_flag_r;
      s3_epoch_r <= s3_epoch_nxt;
      s3_by_r    <= s3_by_nxt;
      s3_doy_r   <= doy_full[8:0];
      s3_m1_r    <= s3_m1_nxt;
      s3_sod_r   <= s2_sod_r;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Month and day from the 32-day grid, hour and second of the day.
  logic [9:0]  grid_pos;
  logic [3:0]  gmon;
  logic [3:0]  gmon_next;
  logic [4:0]  gdom;
  logic [4:0]  beef, cake;
  logic [3:0]  s4_mon_nxt, s4_mon_r;
  logic [4:0]  s4_dom_nxt, s4_dom_r;
  logic [22:0] hour_prod;
  logic [4:0]  s4_hour_nxt, s4_hour_r;
  logic [5:0]  s4_sec_nxt, s4_sec_r;
  logic [7:0]  s4_by_r;
  logic [10:0] s4_m1_r;
  logic [31:0] s4_epoch_r;
  logic        s4_cmd_r, s4_flag_r;

  always_comb begin
    grid_pos  = {1'b0, s3_doy_r} + 10'(GRID_OFFSET);
    gmon      = grid_pos[8:5];
    gdom      = grid_pos[4:0];
    gmon_next = gmon + 4'd1;
    beef      = grid_rem(gmon);
    cake      = grid_rem(gmon_next);
    // Either the day falls in the grid month or it spills into the next one.
    if (gdom <= cake) begin
      s4_mon_nxt = gmon;
      s4_dom_nxt = gdom - beef;
    end else begin
      s4_mon_nxt = gmon_next;
      s4_dom_nxt = gdom - cake;
    end
    hour_prod   = {12'd0, s3_m1_r} * {11'd0, HOUR_RECIP};
    s4_hour_nxt = hour_prod[21:17];
    s4_sec_nxt  = s3_sod_r[5:0] - (s3_m1_r[5:0] * 6'd60);
  end

  always_ff @(posedge clk) begin
    if (s4_rdy) begin
      s4_cmd_r   <= s3_cmd_r;
      s4_flag_r  <= s3_flag_r;
      s4_epoch_r <= s3_epoch_r;
      s4_by_r    <= s3_by_r;
      s4_mon_r   <= s4_mon_nxt;
      s4_dom_r   <= s4_dom_nxt;
      s4_hour_r  <= s4_hour_nxt;
      s4_sec_r   <= s4_sec_nxt;
      s4_m1_r    <= s3_m1_r;
    end
  end

  // ---------------------------------------------------------------- output stage
  // Civil year and month, minute, and zeroing of the fields the command leaves unused.
  logic [31:0] out_epoch_nxt, out_epoch_r;
  logic [11:0] out_year_nxt,  out_year_r;
  logic [3:0]  out_month_nxt, out_month_r;
  logic [4:0]  out_day_nxt,   out_day_r;
  logic [4:0]  out_hour_nxt,  out_hour_r;
  logic [5:0]  out_min_nxt,   out_min_r;
  logic [5:0]  out_sec_nxt,   out_sec_r;
  logic        out_flag_r;

  always_comb begin
    if (s4_cmd_r == CMD_TO_EPOCH) begin
      out_epoch_nxt = s4_epoch_r;
      out_year_nxt  = 12'd0;
      out_month_nxt = 4'd0;
      out_day_nxt   = 5'd0;
      out_hour_nxt  = 5'd0;
      out_min_nxt   = 6'd0;
      out_sec_nxt   = 6'd0;
    end else begin
      out_epoch_nxt = 32'd0;
      // Grid months eleven and twelve are January and February of the next year.
      out_year_nxt  = {4'd0, s4_by_r} + 12'(BASE_YEAR) + {11'd0, (s4_mon_r > 4'd10)};
      out_month_nxt = grid_month(s4_mon_r);
      out_day_nxt   = s4_dom_r;
      out_hour_nxt  = s4_hour_r;
      out_min_nxt   = s4_m1_r[5:0] - ({1'b0, s4_hour_r} * 6'd60);
      out_sec_nxt   = s4_sec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_flag_r  <= s4_flag_r;
      out_epoch_r <= out_epoch_nxt;
      out_year_r  <= out_year_nxt;
      out_month_r <= out_month_nxt;
      out_day_r   <= out_day_nxt;
      out_hour_r  <= out_hour_nxt;
      out_min_r   <= out_min_nxt;
      out_sec_r   <= out_sec_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_flag_r;
  assign out_tdata  = {2'b00, out_sec_r, out_min_r, out_hour_r, out_day_r, out_month_r,
                       out_year_r, out_epoch_r};

endmodule

// ===== rtl/core/ecdc_checker.sv =====
// Port-level checker for the civil date and epoch converter, bound to its top level.
// Depends on ecdc_pkg for the field layout and on the assertion macro header.
`include "epoch_civil_date_converter_macros.svh"

module ecdc_checker
  import ecdc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  // in_tdata: request fields as on the top level
  input logic [71:0] in_tdata,
  // in_tuser: command
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  // out_tdata: result fields as on the top level
  input logic [71:0] out_tdata,
  // out_tuser: out_of_range
  input logic        out_tuser
);

  // Result fields of interest.
  logic [31:0] o_epoch;
  logic [37:0] o_civil;
  logic [3:0]  o_month;
  logic [4:0]  o_hour;
  logic [5:0]  o_min;
  logic [5:0]  o_sec;
  logic        in_req;

  assign o_epoch = out_tdata[OUT_YEAR_LSB-1:OUT_EPOCH_LSB];
  assign o_civil = out_tdata[OUT_USED_MSB:OUT_YEAR_LSB];
  assign o_month = out_tdata[OUT_DAY_LSB-1:OUT_MONTH_LSB];
  assign o_hour  = out_tdata[OUT_MIN_LSB-1:OUT_HOUR_LSB];
  assign o_min   = out_tdata[OUT_SEC_LSB-1:OUT_MIN_LSB];
  assign o_sec   = out_tdata[OUT_USED_MSB:OUT_SEC_LSB];
  assign in_req  = in_tvalid && in_tready && (in_tdata[IN_DATA_W-1] == 1'b0) &&
                   (in_tuser == CMD_TO_EPOCH || in_tuser == CMD_TO_CIVIL);

  // A result that is not taken stays on the port unchanged.
  `ECDC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // The pipeline is empty in the cycle after reset.
  `ECDC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result shown right after reset")

  // A result carries either the epoch count or the civil fields, never both.
  `ECDC_ASSERT(a_one_side, out_tvalid |-> (o_epoch == 32'd0) || (o_civil == 38'd0), "both result halves in use")

  // Civil fields stay inside their calendar ranges.
  `ECDC_ASSERT(a_civil_range, out_tvalid |-> (o_month <= 4'd12) && (o_hour <= 5'd23) && (o_min <= 6'd59) && (o_sec <= 6'd59), "civil field out of range")

  // Nothing leaves the block without an earlier request.
  `ECDC_ASSERT(a_no_invent, $rose(out_tvalid) |-> $past(in_req, 5) || !$past(rst_n, 5) || $past(out_tvalid, 5) || $past(in_tvalid && in_tready, 5) || $past(in_tvalid && in_tready, 6) || $past(in_tvalid && in_tready, 7) || $past(in_tvalid && in_tready, 8) || !$past(out_tready, 1) || !$past(out_tready, 2) || !$past(out_tready, 3) || !$past(out_tready, 4), "result with no request")

endmodule

bind epoch_civil_date_converter ecdc_checker u_ecdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/sv/epoch_civil_date_converter_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the civil date and epoch seconds converter.
// Predicts every result from its own calendar arithmetic and compares it with the stream output.
// Depends on ecdc_pkg and the epoch_civil_date_converter top level.
module epoch_civil_date_converter_tb;
  import ecdc_pkg::*;

  // One conversion request as the block sees it.
  typedef struct packed {
    logic        command;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [31:0] epoch;
  } date_request_t;

  // One conversion result, split into its fields.
  typedef struct packed {
    logic [31:0] epoch;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        out_of_range;
  } date_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // in_tdata from bit 0: year, month, day, hour, minute, second, epoch_in, two zero bits
  logic [71:0] in_tdata;
  // in_tuser: command
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  // out_tdata from bit 0: epoch_out, year_out, month_out, day_out, hour_out, minute_out,
  // second_out, two zero bits
  logic [71:0] out_tdata;
  // out_tuser: out_of_range
  logic        out_tuser;

  // Calendar tables for a year that starts in March.
  logic [8:0] days_before_month [16] = '{0, 306, 337, 0, 31, 61, 92, 122, 153, 184, 214, 245,
                                         275, 0, 0, 0};
  logic [4:0] grid_fix [16] = '{19, 19, 18, 16, 15, 13, 12, 11, 9, 8, 6, 5, 4, 1, 1, 1};
  logic [3:0] grid_to_civil [16] = '{0, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 1, 2, 0, 0, 0};

  date_result_t predicted_conversions [$];
  int unsigned  mismatch_count;
  int unsigned  result_index;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;

  epoch_civil_date_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Predicts the result of one request; all sums wrap at 32 bits as in the block.
  function automatic date_result_t convert_request(input date_request_t r);
    date_result_t res;
    logic [31:0]  yrs, days0, ydays, hh, dnum, sod, by, f0, doy, mon, dom, fix_lo, fix_hi;
    logic [31:0]  civil_year;
    logic [3:0]   next_mon;
    res = '0;
    if (r.command == CMD_TO_EPOCH) begin
      // January and February belong to the March-based year before.
      yrs = 32'(r.year) - BASE_YEAR - ((r.month == 4'd1 || r.month == 4'd2) ? 32'd1 : 32'd0);
      days0 = yrs * DAYS_PER_YEAR + yrs / 32'd4;
      ydays = (r.month <= 4'd12) ? 32'(days_before_month[r.month]) + 32'(r.day) : 32'd0;
      hh = (r.hour <= 5'd24) ? 32'(r.hour) : MAX_HOUR;
      res.epoch = (((days0 + ydays - UNIX_BASE_DAYS) * 32'd24 + hh) * 32'd60
                   + 32'(r.minute)) * 32'd60 + 32'(r.second);
      res.out_of_range = (r.year < YEAR_MIN) || (r.year > YEAR_MAX) ||
                         (r.month < 4'd1) || (r.month > 4'd12);
    end else begin
      dnum = r.epoch / SECS_PER_DAY + UNIX_BASE_DAYS;
      sod = r.epoch % SECS_PER_DAY;
      // Estimate the year, then step back once if the estimate overshoots.
      by = dnum / DAYS_PER_YEAR;
      f0 = by * DAYS_PER_YEAR + by / 32'd4;
      if (f0 >= dnum) begin
        by = by - 32'd1;
        f0 = by * DAYS_PER_YEAR + by / 32'd4;
      end
      doy = dnum - f0;
      // Month on a 32-day grid, then corrected by the remainder table.
      mon = ((doy + GRID_OFFSET) / 32'd32) & 32'hF;
      dom = (doy + GRID_OFFSET) % 32'd32;
      next_mon = mon[3:0] + 4'd1;
      fix_lo = 32'(grid_fix[mon[3:0]]);
      fix_hi = 32'(grid_fix[next_mon]);
      if (dom <= fix_hi) begin
        dom = doy - ((mon - 32'd1) * 32'd32 - GRID_OFFSET + fix_lo);
      end else begin
        dom = doy - (mon * 32'd32 - GRID_OFFSET + fix_hi);
        mon = 32'(next_mon);
      end
      civil_year = by + BASE_YEAR + ((mon > 32'd10) ? 32'd1 : 32'd0);
      res.year = civil_year[11:0];
      res.month = grid_to_civil[mon[3:0]];
      res.day = dom[4:0];
      res.second = 6'(sod % 32'd60);
      res.minute = 6'((sod / 32'd60) % 32'd60);
      res.hour = 5'(sod / 32'd3600);
      res.out_of_range = (r.epoch >= EPOCH_LIMIT);
    end
    return res;
  endfunction

  // Random request: mostly sound dates and epochs, the rest pure noise.
  function automatic date_request_t random_request();
    date_request_t r;
    int unsigned   pick;
    r.command = 1'($urandom);
    r.year = 12'($urandom);
    r.month = 4'($urandom);
    r.day = 5'($urandom);
    r.hour = 5'($urandom);
    r.minute = 6'($urandom);
    r.second = 6'($urandom);
    r.epoch = $urandom;
    pick = $urandom_range(99, 0);
    if (pick < 40) begin
      r.command = CMD_TO_EPOCH;
      r.year = 12'($urandom_range(YEAR_MAX, YEAR_MIN));
      r.month = 4'($urandom_range(12, 1));
      r.day = 5'($urandom_range(31, 1));
      r.hour = 5'($urandom_range(23, 0));
      r.minute = 6'($urandom_range(59, 0));
      r.second = 6'($urandom_range(59, 0));
    end else if (pick < 80) begin
      r.command = CMD_TO_CIVIL;
      // A quarter of the epochs sit on the first or last second of a day.
      if ($urandom_range(3, 0) == 0)
        r.epoch = $urandom_range(47481, 0) * SECS_PER_DAY + $urandom_range(1, 0) * 32'd86399;
      else
        r.epoch = $urandom_range(EPOCH_LIMIT - 32'd1, 0);
    end
    return r;
  endfunction

  // Sends one request with random leading idle cycles and records its prediction.
  task automatic send_request(input date_request_t r);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, r.epoch, r.second, r.minute, r.hour, r.day, r.month, r.year};
    in_tuser <= r.command;
    do @(posedge clk); while (!in_tready);
    predicted_conversions.push_back(convert_request(r));
  endtask

  task automatic send_civil(input int unsigned y, m, d, h, mi, s);
    date_request_t r;
    r = random_request();
    r.command = CMD_TO_EPOCH;
    r.year = 12'(y);
    r.month = 4'(m);
    r.day = 5'(d);
    r.hour = 5'(h);
    r.minute = 6'(mi);
    r.second = 6'(s);
    send_request(r);
  endtask

  task automatic send_epoch(input logic [31:0] t);
    date_request_t r;
    r = random_request();
    r.command = CMD_TO_CIVIL;
    r.epoch = t;
    send_request(r);
  endtask

  // Civil dates at the span edges, the January and February year shift, and bad fields.
  task automatic test_civil_to_epoch_directed();
    send_civil(1970, 1, 1, 0, 0, 0);
    send_civil(2000, 2, 29, 12, 30, 45);
    send_civil(2000, 3, 1, 0, 0, 0);
    send_civil(2024, 12, 31, 23, 59, 59);
    send_civil(2099, 12, 31, 23, 59, 59);
    send_civil(1969, 12, 31, 23, 59, 59);
    send_civil(2100, 1, 1, 0, 0, 0);
    send_civil(2023, 0, 15, 10, 0, 0);
    send_civil(2023, 13, 15, 10, 0, 0);
    send_civil(2023, 15, 31, 31, 63, 63);
    send_civil(2023, 6, 0, 31, 63, 63);
    send_civil(0, 1, 1, 0, 0, 0);
    send_civil(4095, 12, 31, 25, 0, 0);
  endtask

  // Epochs at day and leap-day boundaries, the span limit and the top of the count.
  task automatic test_epoch_to_civil_directed();
    send_epoch(32'd0);
    send_epoch(32'd86399);
    send_epoch(32'd86400);
    send_epoch(32'd68169599);
    send_epoch(32'd951782400);
    send_epoch(32'd1709164800);
    send_epoch(32'h7FFF_FFFF);
    send_epoch(EPOCH_LIMIT - 32'd1);
    send_epoch(EPOCH_LIMIT);
    send_epoch(32'hFFFF_FFFF);
  endtask

  task automatic run_random_requests(input int unsigned count);
    repeat (count) send_request(random_request());
  endtask

  task automatic test_streaming_no_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random_requests(220);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 83;
    recv_stall_pct = 0;
    run_random_requests(220);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 0;
    recv_stall_pct = 83;
    run_random_requests(220);
  endtask

  task automatic test_both_sides_idle();
    send_idle_pct = 26;
    recv_stall_pct = 26;
    run_random_requests(220);
  endtask

  // Main sequence: reset, directed requests, then random traffic under each idling pattern.
  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    result_index = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= CMD_TO_EPOCH;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_civil_to_epoch_directed();
    test_epoch_to_civil_directed();
    test_streaming_no_idle();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_sides_idle();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (predicted_conversions.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Receiver side: ready changes on the falling edge with the current stall rate.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] expected_val,
                             input logic [31:0] actual_val);
    if (expected_val !== actual_val) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%s mismatch on result %0d: expected %0d, got %0d", name, result_index,
                 expected_val, actual_val);
    end
  endtask

  // Compares each accepted result with the oldest prediction, field by field.
  always @(posedge clk) begin
    date_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (predicted_conversions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result %0d: data %h, range flag %b", result_index, out_tdata,
                   out_tuser);
      end else begin
        want = predicted_conversions.pop_front();
        check_field("epoch_out", want.epoch, out_tdata[31:0]);
        check_field("year_out", 32'(want.year), 32'(out_tdata[43:32]));
        check_field("month_out", 32'(want.month), 32'(out_tdata[47:44]));
        check_field("day_out", 32'(want.day), 32'(out_tdata[52:48]));
        check_field("hour_out", 32'(want.hour), 32'(out_tdata[57:53]));
        check_field("minute_out", 32'(want.minute), 32'(out_tdata[63:58]));
        check_field("second_out", 32'(want.second), 32'(out_tdata[69:64]));
        check_field("out_of_range", 32'(want.out_of_range), 32'(out_tuser));
      end
      result_index++;
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
